### rtl/fixed_block_pool_allocator_top_macros.svh
// assertion macros used by the pool allocator datapath
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define FBPA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
`define FBPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FBPA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define FBPA_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### rtl/fbpa_pkg.sv
// shared types, codes and helpers of the block pool allocator
`default_nettype none
package fbpa_pkg;

	// default pool depth and reset slot count
	localparam int MAX_SLOTS_DEF  = 256;
	localparam int SLOT_COUNT_RST = 256;

	// busy flags are stored as rows of this many slots
	localparam int ROW_BITS = 32;
	localparam int BIT_W    = $clog2(ROW_BITS);

	// fixed field widths
	localparam int CFG_W    = 9;
	localparam int SLOT_W   = 8;
	localparam int STATUS_W = 2;
	localparam int USED_W   = 9;

	// request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL         = 2'd1;
	localparam logic [STATUS_W-1:0] ST_ALREADY_FREE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_RANGE        = 2'd3;

	// controller to datapath commands
	typedef struct packed {
		logic capture;
		logic launch;
		logic scan;
		logic reply;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic imm;
		logic done;
		logic out_free;
	} sts_t;

	// index of the lowest set bit of a row
	function automatic logic [BIT_W-1:0] first_set(input logic [ROW_BITS-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = ROW_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### rtl/fbpa_ctrl.sv
// sequencer of the block pool allocator
`default_nettype none
module fbpa_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire fbpa_pkg::sts_t sts,
	output fbpa_pkg::cmd_t     cmd
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_START = 4'b0010,
		S_SCAN  = 4'b0100,
		S_REPLY = 4'b1000
	} state_t;

	state_t state_q, state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (req_valid) state_d = S_START;
			S_START: state_d = sts.imm ? S_REPLY : S_SCAN;
			S_SCAN:  if (sts.done) state_d = S_REPLY;
			S_REPLY: if (sts.out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands to the datapath
	always_comb begin
		cmd.capture = (state_q == S_IDLE) && req_valid;
		cmd.launch  = (state_q == S_START);
		cmd.scan    = (state_q == S_SCAN);
		cmd.reply   = (state_q == S_REPLY) && sts.out_free;
	end

	assign req_stall = (state_q != S_IDLE);

endmodule
`default_nettype wire

### rtl/fbpa_datapath.sv
// busy flag store, search pointers, counters and result register
`default_nettype none
`include "fixed_block_pool_allocator_top_macros.svh"
module fbpa_datapath #(
	parameter int MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire fbpa_pkg::cmd_t                    cmd,
	output fbpa_pkg::sts_t                         sts,
	input  wire logic                              op,
	input  wire logic [fbpa_pkg::SLOT_W-1:0]       slot,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fbpa_pkg::CFG_W-1:0]        slot_count,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [fbpa_pkg::STATUS_W-1:0]          status,
	output logic [fbpa_pkg::SLOT_W-1:0]            granted_slot,
	output logic [fbpa_pkg::USED_W-1:0]            used_count
);

	localparam int ROW_W  = fbpa_pkg::ROW_BITS;
	localparam int BIT_W  = fbpa_pkg::BIT_W;
	localparam int ROWS   = (MAX_SLOTS + ROW_W - 1) / ROW_W;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int PW     = ROW_AW + BIT_W;
	localparam int NW     = PW + 1;
	localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
	localparam int CW     = (NW > fbpa_pkg::CFG_W) ? NW : fbpa_pkg::CFG_W;
	localparam int N_RST  = (MAX_SLOTS < fbpa_pkg::SLOT_COUNT_RST) ?
		MAX_SLOTS : fbpa_pkg::SLOT_COUNT_RST;

	// flag rows, row valid bits and registered read port
	logic [ROW_W-1:0]  mem [ROWS];
	logic [ROWS-1:0]   row_valid_q;
	logic [ROW_W-1:0]  rd_q;
	logic              rd_vld_q;

	// request, config and pool state
	logic                          op_q;
	logic [fbpa_pkg::SLOT_W-1:0]   slot_q;
	logic [NW-1:0]                 n_q;
	logic [CNT_W-1:0]              busy_q;
	logic [PW-1:0]                 next_q;

	// search pointers
	logic [ROW_AW-1:0] row_q;
	logic [ROW_AW-1:0] first_row_q;
	logic [BIT_W-1:0]  lo_q;
	logic              wrapped_q;

	// result and output registers
	logic [fbpa_pkg::STATUS_W-1:0] res_status_q;
	logic [fbpa_pkg::SLOT_W-1:0]   res_granted_q;
	logic [fbpa_pkg::USED_W-1:0]   res_used_q;
	logic                          rsp_valid_q;
	logic [fbpa_pkg::STATUS_W-1:0] status_q;
	logic [fbpa_pkg::SLOT_W-1:0]   granted_q;
	logic [fbpa_pkg::USED_W-1:0]   used_q;

	// combinational helpers
	logic [CW-1:0]     n_ext, busy_ext, slot_ext, next_ext, sc_ext, n_cfg;
	logic [PW-1:0]     p0, slot_pos, hit_pos;
	logic              alloc_full, range_bad, is_alloc;
	logic [ROW_W-1:0]  eff_row, cand, free_bits, wr_data;
	logic              hit, scan_fail, free_bit, last_row;
	logic [BIT_W-1:0]  hit_bit, slot_bit;
	logic [NW-1:0]     next_base, hit_inc;
	logic              rd_en, we;
	logic [ROW_AW-1:0] rd_row;
	logic [CNT_W-1:0]  busy_d;
	logic [CW-1:0]     busy_d_ext, hit_pos_ext;
	logic [fbpa_pkg::STATUS_W-1:0] scan_status;
	logic [fbpa_pkg::SLOT_W-1:0]   scan_granted;

	// request classification
	always_comb begin
		is_alloc   = (op_q == fbpa_pkg::OP_ALLOC);
		n_ext      = CW'(n_q);
		busy_ext   = CW'(busy_q);
		slot_ext   = CW'(slot_q);
		next_ext   = CW'(next_q);
		p0         = (next_ext < n_ext) ? next_q : '0;
		slot_pos   = slot_ext[PW-1:0];
		slot_bit   = slot_pos[BIT_W-1:0];
		alloc_full = (busy_ext >= n_ext);
		range_bad  = (slot_ext >= n_ext);
	end

	// candidate slots of the current row
	always_comb begin
		eff_row = rd_vld_q ? rd_q : '0;
		for (int i = 0; i < ROW_W; i++) begin
			cand[i] = (NW'({row_q, BIT_W'(i)}) < n_q) && (BIT_W'(i) >= lo_q);
		end
		free_bits = ~eff_row & cand;
		hit       = |free_bits;
		hit_bit   = fbpa_pkg::first_set(free_bits);
		hit_pos   = {row_q, hit_bit};
		next_base = NW'({row_q, BIT_W'(0)}) + NW'(ROW_W);
		last_row  = (next_base >= n_q);
		scan_fail = !hit && wrapped_q && (row_q == first_row_q);
		free_bit  = eff_row[slot_bit];
		hit_inc   = NW'(hit_pos) + NW'(1);
	end

	// status to the controller
	always_comb begin
		sts.imm      = is_alloc ? alloc_full : range_bad;
		sts.done     = !is_alloc || hit || scan_fail;
		sts.out_free = !rsp_valid_q || !rsp_stall;
	end

	// read port control
	always_comb begin
		rd_en  = 1'b0;
		rd_row = row_q;
		if (cmd.launch && !sts.imm) begin
			rd_en  = 1'b1;
			rd_row = is_alloc ? p0[PW-1:BIT_W] : slot_pos[PW-1:BIT_W];
		end else if (cmd.scan && !sts.done) begin
			rd_en  = 1'b1;
			rd_row = last_row ? '0 : row_q + ROW_AW'(1);
		end
	end

	// write port control and next count
	always_comb begin
		we      = cmd.scan && (is_alloc ? hit : free_bit);
		wr_data = is_alloc ? (eff_row | (ROW_W'(1) << hit_bit))
			: (eff_row & ~(ROW_W'(1) << slot_bit));
		busy_d  = busy_q;
		if (we) begin
			if (is_alloc) busy_d = busy_q + CNT_W'(1);
			else if (busy_q != '0) busy_d = busy_q - CNT_W'(1);
		end
		busy_d_ext  = CW'(busy_d);
		hit_pos_ext = CW'(hit_pos);
	end

	// result of a finished scan
	always_comb begin
		scan_status  = fbpa_pkg::ST_OK;
		scan_granted = '0;
		if (is_alloc) begin
			if (hit) scan_granted = hit_pos_ext[fbpa_pkg::SLOT_W-1:0];
			else scan_status = fbpa_pkg::ST_FULL;
		end else if (!free_bit) begin
			scan_status = fbpa_pkg::ST_ALREADY_FREE;
		end
	end

	// flag memory
	always_ff @(posedge clk) begin
		if (we) mem[row_q] <= wr_data;
		if (rd_en) rd_q <= mem[rd_row];
	end

	// row valid bits and read valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_vld_q    <= 1'b0;
		end else begin
			if (we) row_valid_q[row_q] <= 1'b1;
			if (rd_en) rd_vld_q <= row_valid_q[rd_row];
		end
	end

	// slot count register with clamping
	always_comb begin
		sc_ext = CW'(slot_count);
		if (sc_ext == '0) n_cfg = CW'(1);
		else if (sc_ext > CW'(MAX_SLOTS)) n_cfg = CW'(MAX_SLOTS);
		else n_cfg = sc_ext;
	end

	assign cfg_ready = 1'b1;

	// pool state and search pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= NW'(N_RST);
			busy_q    <= '0;
			next_q    <= '0;
			wrapped_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) n_q <= n_cfg[NW-1:0];
			busy_q <= busy_d;
			if (we && is_alloc) next_q <= (hit_inc == n_q) ? '0 : hit_inc[PW-1:0];
			if (cmd.launch) wrapped_q <= 1'b0;
			else if (rd_en && last_row) wrapped_q <= 1'b1;
		end
	end

	// request capture and scan row pointers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= op;
			slot_q <= slot;
		end
		if (rd_en) row_q <= rd_row;
		if (cmd.launch) begin
			first_row_q <= rd_row;
			lo_q        <= is_alloc ? p0[BIT_W-1:0] : '0;
		end else if (rd_en) begin
			lo_q <= '0;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.launch && sts.imm) begin
			res_status_q  <= is_alloc ? fbpa_pkg::ST_FULL : fbpa_pkg::ST_RANGE;
			res_granted_q <= '0;
			res_used_q    <= busy_ext[fbpa_pkg::USED_W-1:0];
		end else if (cmd.scan && sts.done) begin
			res_status_q  <= scan_status;
			res_granted_q <= scan_granted;
			res_used_q    <= busy_d_ext[fbpa_pkg::USED_W-1:0];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.reply) rsp_valid_q <= 1'b1;
			else if (!rsp_stall) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			status_q  <= res_status_q;
			granted_q <= res_granted_q;
			used_q    <= res_used_q;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign used_count   = used_q;

	// checks
	`FBPA_ASSERT_ALWAYS(a_busy_bound, clk, arst_n, busy_q <= CNT_W'(MAX_SLOTS))
	`FBPA_ASSERT_IMPL(a_reply_room, clk, arst_n, cmd.reply, !rsp_valid_q || !rsp_stall)
	`FBPA_ASSERT_NEXT(a_grant_count, clk, arst_n, cmd.scan && is_alloc && hit, busy_q == $past(busy_q) + CNT_W'(1) && res_status_q == fbpa_pkg::ST_OK)

endmodule
`default_nettype wire

### rtl/fixed_block_pool_allocator_top.sv
// top level of the fixed block pool allocator
// A pool of MAX_SLOTS equal slots handed out next-fit. A request is accepted and set up,
// scans the 32-slot flag rows it needs, and then presents its reply. The scan reads
// one row of busy flags per cycle from a single-port flag memory. An allocate visits
// at most 1 + ceil(n/32) rows, with n the active slot count; a free visits only the
// row of its slot and an immediate failure none. A row that was never written reads
// as all free through a per-row valid bit, so no clearing pass follows reset. The reply
// sits in an output register, and the next request is taken while it waits. slot_count
// may only be written while no request is in flight.
`default_nettype none
module fixed_block_pool_allocator_top #(
	parameter int MAX_SLOTS = fbpa_pkg::MAX_SLOTS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic                              op,
	input  wire logic [fbpa_pkg::SLOT_W-1:0]       slot,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fbpa_pkg::CFG_W-1:0]        slot_count,
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic [fbpa_pkg::STATUS_W-1:0]          status,
	output logic [fbpa_pkg::SLOT_W-1:0]            granted_slot,
	output logic [fbpa_pkg::USED_W-1:0]            used_count
);

	fbpa_pkg::cmd_t cmd;
	fbpa_pkg::sts_t sts;

	// request sequencer
	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// flag store and counters
	fbpa_datapath #(
		.MAX_SLOTS (MAX_SLOTS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.op           (op),
		.slot         (slot),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.slot_count   (slot_count),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.granted_slot (granted_slot),
		.used_count   (used_count)
	);

endmodule
`default_nettype wire

### tb/sv/testbench.sv
// self-checking testbench of the fixed block pool allocator with a next-fit slot predictor
module testbench;
	import fbpa_pkg::*;

	typedef struct packed {
		logic              op;
		logic [SLOT_W-1:0] slot;
	} pool_req_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [SLOT_W-1:0]   granted;
		logic [USED_W-1:0]   used;
	} pool_reply_t;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_WAIT  = 16;
	localparam int HOLD_CYCLES = 400;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              req_valid = 1'b0;
	logic              req_stall;
	logic              req_op = OP_ALLOC;
	logic [SLOT_W-1:0] req_slot = '0;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_W-1:0]  cfg_slots = '0;
	logic              rsp_valid;
	logic              rsp_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [SLOT_W-1:0]   granted_slot;
	logic [USED_W-1:0]   used_count;

	// shadow of the pool as the block should hold it
	bit               busy_map [MAX_SLOTS_DEF];
	int               next_idx = 0;
	int               busy_cnt = 0;
	logic [CFG_W-1:0] cfg_shadow = CFG_W'(SLOT_COUNT_RST);

	pool_req_t   pending_q[$];
	pool_reply_t reply_q[$];

	int  pushed_cnt = 0;
	int  accepted_cnt = 0;
	int  replies_seen = 0;
	int  cfg_writes = 0;
	int  mismatches = 0;
	int  n_ok = 0, n_full = 0, n_afree = 0, n_range = 0;
	bit  req_fire = 1'b0;
	bit  idle_on = 1'b1;
	int  hold_asked = 0;
	int  hold_seen = 0;
	int  send_gap = 0;
	int  rsp_gap = 0;
	int  rsp_hold = 0;
	int  quiet_cycles = 0;

	fixed_block_pool_allocator_top DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.req_valid    (req_valid),
		.req_stall    (req_stall),
		.op           (req_op),
		.slot         (req_slot),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.slot_count   (cfg_slots),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.status       (status),
		.granted_slot (granted_slot),
		.used_count   (used_count)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// number of slots actually in use for a slot_count setting
	function automatic int active_of(input logic [CFG_W-1:0] c);
		if (c == 0) return 1;
		if (c > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
		return int'(c);
	endfunction

	// next-fit allocate or free on the shadow pool
	task automatic pool_step(input pool_req_t rq, output pool_reply_t rp);
		int n;
		int pos;
		int k;
		bit found;
		n = active_of(cfg_shadow);
		rp = '{ST_OK, '0, '0};
		if (rq.op == OP_ALLOC) begin
			if (busy_cnt >= n) begin
				rp.status = ST_FULL;
			end else begin
				pos = (next_idx < n) ? next_idx : 0;
				found = 1'b0;
				for (k = 0; k < n && !found; k++) begin
					if (!busy_map[pos]) begin
						found = 1'b1;
					end else begin
						pos++;
						if (pos >= n) pos = 0;
					end
				end
				if (found) begin
					busy_map[pos] = 1'b1;
					busy_cnt++;
					rp.granted = SLOT_W'(pos);
					next_idx = (pos + 1) % n;
				end else begin
					rp.status = ST_FULL;
				end
			end
		end else begin
			if (rq.slot >= n) begin
				rp.status = ST_RANGE;
			end else if (!busy_map[rq.slot]) begin
				rp.status = ST_ALREADY_FREE;
			end else begin
				busy_map[rq.slot] = 1'b0;
				if (busy_cnt > 0) busy_cnt--;
			end
		end
		rp.used = USED_W'(busy_cnt);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $time, msg);
		mismatches++;
	endtask

	// request driver, one request in flight on the port at a time
	always @(negedge clk) begin
		pool_req_t nxt;
		if (arst_n && !(req_valid && !req_fire)) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (pending_q.size() != 0) begin
				if (idle_on && $urandom_range(7) == 0) begin
					send_gap = $urandom_range(1, 14) - 1;
					req_valid <= 1'b0;
				end else begin
					nxt = pending_q.pop_front();
					req_op <= nxt.op;
					req_slot <= nxt.slot;
					req_valid <= 1'b1;
				end
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// reply side stall: random bursts plus an occasional long hold-off
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_seen != hold_asked) begin
				hold_seen++;
				rsp_hold = HOLD_CYCLES;
			end
			if (rsp_hold > 0) begin
				rsp_hold--;
				rsp_stall <= 1'b1;
			end else if (rsp_gap > 0) begin
				rsp_gap--;
				rsp_stall <= 1'b1;
			end else if (idle_on && $urandom_range(7) == 0) begin
				rsp_gap = $urandom_range(1, 14) - 1;
				rsp_stall <= 1'b1;
			end else begin
				rsp_stall <= 1'b0;
			end
		end
	end

	// monitor: check replies, predict accepted requests, track register writes
	always @(posedge clk) begin
		pool_reply_t want;
		pool_reply_t got_exp;
		if (arst_n) begin
			req_fire <= req_valid && !req_stall;
			if (rsp_valid && !rsp_stall) begin
				replies_seen++;
				if (reply_q.size() == 0) begin
					report_mismatch($sformatf("reply %0d arrived with none expected",
						replies_seen));
				end else begin
					want = reply_q.pop_front();
					if (status !== want.status)
						report_mismatch($sformatf("reply %0d status %0d, expected %0d",
							replies_seen, status, want.status));
					if (granted_slot !== want.granted)
						report_mismatch($sformatf("reply %0d granted_slot %0d, expected %0d",
							replies_seen, granted_slot, want.granted));
					if (used_count !== want.used)
						report_mismatch($sformatf("reply %0d used_count %0d, expected %0d",
							replies_seen, used_count, want.used));
					case (want.status)
						ST_OK:           n_ok++;
						ST_FULL:         n_full++;
						ST_ALREADY_FREE: n_afree++;
						ST_RANGE:        n_range++;
						default:         ;
					endcase
				end
			end
			if (req_valid && !req_stall) begin
				pool_step('{req_op, req_slot}, got_exp);
				reply_q.push_back(got_exp);
				accepted_cnt++;
			end
			if (cfg_valid && cfg_ready) begin
				cfg_shadow = cfg_slots;
				cfg_writes++;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no handshake for %0d cycles", quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_item(input logic op_v, input logic [SLOT_W-1:0] slot_v);
		pending_q.push_back('{op_v, slot_v});
		pushed_cnt++;
	endtask

	// wait until every request is taken and answered, then let the block settle
	task automatic wait_drained();
		while (accepted_cnt != pushed_cnt || reply_q.size() != 0)
			@(negedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_slot_count(input logic [CFG_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_slots <= v;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// one random stretch at a given slot count and allocate share
	task automatic run_phase(input logic [CFG_W-1:0] cfg, input int count,
			input int alloc_pct, input bit calm, input bit squeeze);
		int lim;
		write_slot_count(cfg);
		idle_on = !calm;
		if (squeeze) hold_asked++;
		lim = active_of(cfg);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(99) < alloc_pct)
				push_item(OP_ALLOC, SLOT_W'($urandom));
			else if ($urandom_range(4) == 0)
				push_item(OP_FREE, SLOT_W'($urandom));
			else
				push_item(OP_FREE, SLOT_W'($urandom_range(lim - 1)));
		end
		wait_drained();
	endtask

	// stimulus sequence
	initial begin
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// full-size pool: free of free slots, a few grants, next-fit after a free
		push_item(OP_FREE, 8'h00);
		push_item(OP_FREE, 8'hFF);
		push_item(OP_ALLOC, 8'hFF);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_ALLOC, 8'h5A);
		push_item(OP_FREE, 8'h01);
		push_item(OP_ALLOC, 8'hA5);
		wait_drained();

		// shrink below next index, fill up, free while full
		write_slot_count(9'd4);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_FREE, 8'hFF);
		push_item(OP_FREE, 8'h03);
		push_item(OP_ALLOC, 8'h00);
		wait_drained();

		// busy slots stranded beyond the active count
		write_slot_count(9'd2);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_FREE, 8'h03);
		push_item(OP_FREE, 8'h01);
		push_item(OP_ALLOC, 8'h00);
		wait_drained();

		// zero slot count acts as one slot
		write_slot_count(9'd0);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_FREE, 8'h00);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_FREE, 8'h01);
		wait_drained();

		// oversize slot count clamps to the pool size, stranded slots freed again
		write_slot_count(9'h1FF);
		push_item(OP_FREE, 8'h02);
		push_item(OP_FREE, 8'h03);
		push_item(OP_ALLOC, 8'h00);
		push_item(OP_FREE, 8'h80);
		wait_drained();

		// random part
		run_phase(9'd256, 450, 85, 1'b0, 1'b0);
		run_phase(9'h1FF, 200, 15, 1'b0, 1'b0);
		run_phase(9'd37, 100, 60, 1'b0, 1'b0);
		run_phase(9'd1, 40, 50, 1'b0, 1'b0);
		run_phase(9'd2, 40, 50, 1'b0, 1'b0);
		run_phase(9'd0, 30, 50, 1'b0, 1'b0);
		run_phase(9'd64, 120, 70, 1'b1, 1'b1);
		run_phase(9'd33, 100, 65, 1'b0, 1'b0);
		run_phase(9'd300, 60, 45, 1'b0, 1'b0);
		run_phase(9'd255, 100, 80, 1'b1, 1'b0);

		$display("summary: %0d requests under %0d slot-count writes, %0d replies checked",
			pushed_cnt, cfg_writes, replies_seen);
		$display("summary: ok %0d, pool full %0d, already free %0d, out of range %0d",
			n_ok, n_full, n_afree, n_range);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/fbpa_pkg.sv
rtl/fbpa_ctrl.sv
rtl/fbpa_datapath.sv
rtl/fixed_block_pool_allocator_top.sv
tb/sv/testbench.sv
